FILE: design/skb_pkg.sv
package skb_pkg;

  localparam int MAX_SPRITES_DEF = 64;
  localparam int IDX_W           = 6;
  localparam int CNT_W           = 7;
  localparam int TEX_W           = 32;
  localparam int DEPTH_W         = 32;
  localparam int VTX_W           = 9;
  localparam int VERTS           = 6;

  typedef enum logic [1:0] {
    MODE_NONE       = 2'd0,
    MODE_DEPTH_ASC  = 2'd1,
    MODE_DEPTH_DESC = 2'd2,
    MODE_TEX_ASC    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_RUN,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT,
    OP_RUN,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic [TEX_W-1:0]          texture_id;
    logic signed [DEPTH_W-1:0] depth_key;
    logic                      last_sprite;
  } sprite_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] sprite_index;
    logic [TEX_W-1:0] texture_out;
    logic             batch_start;
    logic [VTX_W-1:0] batch_vertex_offset;
    logic [VTX_W-1:0] batch_vertex_count;
    logic             overflow;
    logic             last_out;
  } result_t;

  // one stored sprite, run is the number of records from it to the end of its texture run
  typedef struct packed {
    logic [TEX_W-1:0]          tex;
    logic signed [DEPTH_W-1:0] depth;
    logic [IDX_W-1:0]          idx;
    logic [CNT_W-1:0]          run;
  } rec_t;

  typedef struct packed {
    cell_op_t         op;
    mode_t            mode;
    logic             odd;
    logic [IDX_W-1:0] wr_sel;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

FILE: design/skb_stream_if.sv
interface skb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/skb_cell.sv
module skb_cell #(
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  skb_pkg::cell_ctrl_t ctrl,
  input  skb_pkg::sprite_in_t in_item,
  input  skb_pkg::rec_t       left_rec,
  input  skb_pkg::rec_t       right_rec,
  input  logic                swap_left,
  output skb_pkg::rec_t       rec,
  output logic                swap_right
);

  skb_pkg::rec_t rec_next;
  logic          right_valid;
  logic          pair_here;
  logic          ahead;

  assign right_valid = (skb_pkg::CNT_W'(INDEX + 1) < ctrl.count);
  assign pair_here   = right_valid && (ctrl.odd == 1'(INDEX % 2));

  // right neighbor strictly belongs ahead of this cell
  always_comb begin
    case (ctrl.mode)
      skb_pkg::MODE_DEPTH_ASC:  ahead = $signed(right_rec.depth) < $signed(rec.depth);
      skb_pkg::MODE_DEPTH_DESC: ahead = $signed(right_rec.depth) > $signed(rec.depth);
      skb_pkg::MODE_TEX_ASC:    ahead = right_rec.tex < rec.tex;
      default:                  ahead = 1'b0;
    endcase
  end

  assign swap_right = (ctrl.op == skb_pkg::OP_SORT) && pair_here && ahead;

  always_comb begin
    rec_next = rec;
    case (ctrl.op)
      skb_pkg::OP_LOAD: begin
        if (ctrl.wr_sel == skb_pkg::IDX_W'(INDEX)) begin
          rec_next.tex   = in_item.texture_id;
          rec_next.depth = in_item.depth_key;
          rec_next.idx   = skb_pkg::IDX_W'(INDEX);
        end
      end
      skb_pkg::OP_SORT: begin
        if (swap_right) begin
          rec_next = right_rec;
        end else if (swap_left) begin
          rec_next = left_rec;
        end
      end
      skb_pkg::OP_RUN: begin
        if (right_valid && (right_rec.tex == rec.tex)) begin
          rec_next.run = right_rec.run + skb_pkg::CNT_W'(1);
        end else begin
          rec_next.run = skb_pkg::CNT_W'(1);
        end
      end
      skb_pkg::OP_SHIFT: rec_next = right_rec;
      default:           rec_next = rec;
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

FILE: design/skb_ctrl.sv
module skb_ctrl #(
  parameter int MAX_SPRITES = skb_pkg::MAX_SPRITES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  skb_stream_if.sink           sprites,
  skb_stream_if.source         results,
  input  skb_pkg::mode_t       mode,
  input  skb_pkg::rec_t        head,
  output skb_pkg::cell_ctrl_t  ctrl
);

  skb_pkg::state_t           state;
  skb_pkg::state_t           state_next;
  logic [skb_pkg::CNT_W-1:0] count;
  logic                      ovf;
  logic [skb_pkg::IDX_W-1:0] step;
  logic [skb_pkg::IDX_W-1:0] pos;
  logic [skb_pkg::TEX_W-1:0] prev_tex;

  logic                      accept;
  logic                      store;
  logic                      take;
  logic [skb_pkg::CNT_W-1:0] last_pos;
  logic                      step_end;
  logic                      pos_end;
  logic                      start;

  assign accept   = sprites.valid && sprites.ready;
  assign store    = accept && (count < skb_pkg::CNT_W'(MAX_SPRITES));
  assign take     = results.valid && results.ready;
  assign last_pos = count - skb_pkg::CNT_W'(1);
  assign step_end = ({1'b0, step} == last_pos);
  assign pos_end  = ({1'b0, pos} == last_pos);

  always_comb begin
    state_next = state;
    case (state)
      skb_pkg::ST_LOAD: if (accept && sprites.payload.last_sprite) state_next = skb_pkg::ST_SORT;
      skb_pkg::ST_SORT: if (step_end) state_next = skb_pkg::ST_RUN;
      skb_pkg::ST_RUN:  if (step_end) state_next = skb_pkg::ST_EMIT;
      skb_pkg::ST_EMIT: if (take && pos_end) state_next = skb_pkg::ST_LOAD;
      default:          state_next = skb_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    sprites.ready = (state == skb_pkg::ST_LOAD);
    results.valid = (state == skb_pkg::ST_EMIT);
    ctrl.mode     = mode;
    ctrl.odd      = step[0];
    ctrl.wr_sel   = count[skb_pkg::IDX_W-1:0];
    ctrl.count    = count;
    case (state)
      skb_pkg::ST_LOAD: ctrl.op = store ? skb_pkg::OP_LOAD : skb_pkg::OP_HOLD;
      skb_pkg::ST_SORT: ctrl.op = skb_pkg::OP_SORT;
      skb_pkg::ST_RUN:  ctrl.op = skb_pkg::OP_RUN;
      skb_pkg::ST_EMIT: ctrl.op = take ? skb_pkg::OP_SHIFT : skb_pkg::OP_HOLD;
      default:          ctrl.op = skb_pkg::OP_HOLD;
    endcase
  end

  assign start = (pos == '0) || (head.tex != prev_tex);

  always_comb begin
    results.payload.sprite_index        = head.idx;
    results.payload.texture_out         = head.tex;
    results.payload.batch_start         = start;
    results.payload.batch_vertex_offset =
      start ? skb_pkg::VTX_W'(pos) * skb_pkg::VTX_W'(skb_pkg::VERTS) : '0;
    results.payload.batch_vertex_count  =
      start ? skb_pkg::VTX_W'(head.run) * skb_pkg::VTX_W'(skb_pkg::VERTS) : '0;
    results.payload.overflow            = ovf;
    results.payload.last_out            = pos_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skb_pkg::ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      step  <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      case (state)
        skb_pkg::ST_LOAD: begin
          step <= '0;
          pos  <= '0;
          if (store) begin
            count <= count + skb_pkg::CNT_W'(1);
          end else if (accept) begin
            ovf <= 1'b1;
          end
        end
        skb_pkg::ST_SORT, skb_pkg::ST_RUN: begin
          step <= step_end ? '0 : step + skb_pkg::IDX_W'(1);
        end
        skb_pkg::ST_EMIT: begin
          if (take) begin
            pos <= pos + skb_pkg::IDX_W'(1);
            if (pos_end) begin
              count <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: step <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_tex <= head.tex;
    end
  end

endmodule

FILE: design/sprite_key_sort_and_batch.sv
// sprite key sort and run-length batcher
// sprites: input items (texture_id, depth_key, last_sprite), one per cycle while
//   loading; each is tagged with its arrival index and written to the next cell
// cfg: writes sort_mode (none, depth ascending, depth descending, texture
//   ascending); always ready, write only between loads
// results: one item per stored sprite in sorted order, with batch_start and
//   the batch vertex offset and count on the first item of each texture run
// sequence: after the item marked last is taken, odd-even exchange runs in the
//   cell row, then run-length propagation, then results leave at one per cycle
//   from cell 0 while the receiver is ready
// throughput: loading takes one item per cycle; a load occupies the block from
//   its first sprite until its last result is taken
// sprites beyond MAX_SPRITES are taken and dropped and the overflow flag is
//   raised on every result of that load
// reset: empty store, sort mode none, no results pending
// a stalled receiver holds the head cell and the whole row in place; no new
//   sprite is taken until the last result of the load is delivered
module sprite_key_sort_and_batch #(
  parameter int MAX_SPRITES = skb_pkg::MAX_SPRITES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  skb_stream_if.sink   sprites,
  skb_stream_if.sink   cfg,
  skb_stream_if.source results
);

  skb_pkg::mode_t      mode;
  skb_pkg::cell_ctrl_t ctrl;

  // cell records and the exchange flags between neighbors
  skb_pkg::rec_t recs     [MAX_SPRITES];
  skb_pkg::rec_t left_in  [MAX_SPRITES];
  skb_pkg::rec_t right_in [MAX_SPRITES];
  logic          swaps    [MAX_SPRITES];
  logic          swap_in  [MAX_SPRITES];

  // mode register, sampled by the cells throughout the sort
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= skb_pkg::MODE_NONE;
    end else if (cfg.valid) begin
      mode <= skb_pkg::mode_t'(cfg.payload);
    end
  end

  // sequencer: load, sort, run count, emit
  skb_ctrl #(
    .MAX_SPRITES(MAX_SPRITES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .sprites (sprites),
    .results (results),
    .mode    (mode),
    .head    (recs[0]),
    .ctrl    (ctrl)
  );

  // row of cells, cell 0 is the head that feeds the result channel
  for (genvar i = 0; i < MAX_SPRITES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = '0;
      assign swap_in[i] = 1'b0;
    end else begin : g_mid
      assign left_in[i] = recs[i-1];
      assign swap_in[i] = swaps[i-1];
    end

    // the tail has no right neighbor; it never pairs and shifts in filler
    if (i == MAX_SPRITES - 1) begin : g_last
      assign right_in[i] = '0;
    end else begin : g_inner
      assign right_in[i] = recs[i+1];
    end

    skb_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .in_item    (sprites.payload),
      .left_rec   (left_in[i]),
      .right_rec  (right_in[i]),
      .swap_left  (swap_in[i]),
      .rec        (recs[i]),
      .swap_right (swaps[i])
    );
  end

endmodule

FILE: tb/tb.sv
module tb;

  localparam int CAPACITY       = skb_pkg::MAX_SPRITES_DEF;
  // cycles of margin after the last result: a full sort, a run pass and some slack
  localparam int DRAIN_CYCLES   = 3 * CAPACITY + 20;
  // far above the slowest correct run of about 250 items with maximum gaps and stalls
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int RANDOM_ITEMS   = 50;

  logic clk;
  logic rst;
  logic sink_ready = 1'b0;

  skb_stream_if #(.payload_t(skb_pkg::sprite_in_t)) sprites ();
  skb_stream_if #(.payload_t(skb_pkg::mode_t))      cfg ();
  skb_stream_if #(.payload_t(skb_pkg::result_t))    results ();

  assign results.ready = sink_ready;

  sprite_key_sort_and_batch uut (
    .clk     (clk),
    .rst     (rst),
    .sprites (sprites),
    .cfg     (cfg),
    .results (results)
  );

  // shadow copy of the sprite store, the load state and the sort mode
  logic [skb_pkg::TEX_W-1:0]          shadow_tex   [CAPACITY];
  logic signed [skb_pkg::DEPTH_W-1:0] shadow_depth [CAPACITY];
  int                                 shadow_count;
  bit                                 shadow_overflow;
  skb_pkg::mode_t                     shadow_mode;

  // sorted batch items still owed by the block, oldest first
  skb_pkg::result_t batch_queue[$];

  int  mismatches;
  int  unexpected;
  int  items_sent;
  // per-load switches for stretches with no idling on either side
  bit  sender_steady;
  bit  sink_steady;
  int  sink_wait;
  int  sink_draw;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // strict ordering for the stable insertion sort; ties never move a sprite
  function automatic bit sorts_ahead(int a, int b);
    case (shadow_mode)
      skb_pkg::MODE_DEPTH_ASC:  return shadow_depth[a] < shadow_depth[b];
      skb_pkg::MODE_DEPTH_DESC: return shadow_depth[a] > shadow_depth[b];
      skb_pkg::MODE_TEX_ASC:    return shadow_tex[a] < shadow_tex[b];
      default:                  return 1'b0;
    endcase
  endfunction

  // store one accepted sprite; on the last one sort the load and queue its batch items
  function automatic void absorb_sprite(skb_pkg::sprite_in_t s);
    int               order [CAPACITY];
    int               i;
    int               j;
    int               cur;
    int               q;
    bit               start;
    skb_pkg::result_t r;
    if (shadow_count < CAPACITY) begin
      shadow_tex[shadow_count]   = s.texture_id;
      shadow_depth[shadow_count] = s.depth_key;
      shadow_count++;
    end else begin
      // store full: sprite dropped, but a last mark still closes the load
      shadow_overflow = 1'b1;
    end
    if (!s.last_sprite) return;

    for (i = 0; i < shadow_count; i++) order[i] = i;
    for (i = 1; i < shadow_count; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && sorts_ahead(cur, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end

    for (i = 0; i < shadow_count; i++) begin
      start = (i == 0) || (shadow_tex[order[i]] != shadow_tex[order[i-1]]);
      r = '0;
      r.sprite_index = skb_pkg::IDX_W'(order[i]);
      r.texture_out  = shadow_tex[order[i]];
      r.batch_start  = start;
      if (start) begin
        // run length: this sprite and the following ones sharing its texture
        q = i + 1;
        while (q < shadow_count && shadow_tex[order[q]] == shadow_tex[order[i]]) q++;
        r.batch_vertex_offset = skb_pkg::VTX_W'(skb_pkg::VERTS * i);
        r.batch_vertex_count  = skb_pkg::VTX_W'(skb_pkg::VERTS * (q - i));
      end
      r.overflow = shadow_overflow;
      r.last_out = (i == shadow_count - 1);
      batch_queue = {batch_queue, r};
    end
    shadow_count    = 0;
    shadow_overflow = 1'b0;
  endfunction

  function automatic void check_result(skb_pkg::result_t got);
    skb_pkg::result_t want;
    bit               bad;
    if (batch_queue.size() == 0) begin
      unexpected++;
      if (mismatches + unexpected <= 10)
        $display("unexpected item: idx %0d tex %h start %0d off %0d cnt %0d ovf %0d last %0d",
                 got.sprite_index, got.texture_out, got.batch_start,
                 got.batch_vertex_offset, got.batch_vertex_count, got.overflow,
                 got.last_out);
      return;
    end
    want = batch_queue.pop_front();
    bad = 1'b0;
    if (got.sprite_index        !== want.sprite_index)        bad = 1'b1;
    if (got.texture_out         !== want.texture_out)         bad = 1'b1;
    if (got.batch_start         !== want.batch_start)         bad = 1'b1;
    if (got.batch_vertex_offset !== want.batch_vertex_offset) bad = 1'b1;
    if (got.batch_vertex_count  !== want.batch_vertex_count)  bad = 1'b1;
    if (got.overflow            !== want.overflow)            bad = 1'b1;
    if (got.last_out            !== want.last_out)            bad = 1'b1;
    if (bad) begin
      mismatches++;
      if (mismatches + unexpected <= 10) begin
        $display("mismatch: expected idx %0d tex %h start %0d off %0d cnt %0d ovf %0d last %0d",
                 want.sprite_index, want.texture_out, want.batch_start,
                 want.batch_vertex_offset, want.batch_vertex_count, want.overflow,
                 want.last_out);
        $display("          actual   idx %0d tex %h start %0d off %0d cnt %0d ovf %0d last %0d",
                 got.sprite_index, got.texture_out, got.batch_start,
                 got.batch_vertex_offset, got.batch_vertex_count, got.overflow,
                 got.last_out);
      end
    end
  endfunction

  // result side: check every accepted item, then stall for a random draw before the next unless steady
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      sink_wait  <= 0;
    end else if (results.valid && sink_ready) begin
      check_result(results.payload);
      sink_draw = sink_steady ? 0 : $urandom_range(0, 5);
      if (sink_draw != 0) begin
        sink_ready <= 1'b0;
        sink_wait  <= sink_draw;
      end
    end else if (!sink_ready) begin
      if (sink_wait <= 1) begin
        sink_ready <= 1'b1;
        sink_wait  <= 0;
      end else begin
        sink_wait <= sink_wait - 1;
      end
    end
  end

  // hold valid through the handshake; within this task valid is only lowered when a gap is drawn
  task automatic send_sprite(input logic [skb_pkg::TEX_W-1:0]   tex,
                             input logic [skb_pkg::DEPTH_W-1:0] depth,
                             input bit last);
    int                  gap;
    skb_pkg::sprite_in_t item;
    item.texture_id  = tex;
    item.depth_key   = depth;
    item.last_sprite = last;
    gap = sender_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      sprites.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sprites.payload <= item;
    sprites.valid   <= 1'b1;
    @(posedge clk);
    while (!sprites.ready) @(posedge clk);
    absorb_sprite(item);
    items_sent++;
  endtask

  // sender lowers valid and pauses until every owed item has come, then idles to settle
  task automatic wait_drained;
    sprites.valid <= 1'b0;
    while (batch_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input skb_pkg::mode_t m);
    wait_drained();
    cfg.payload <= m;
    cfg.valid   <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid   <= 1'b0;
    shadow_mode = m;
  endtask

  // single-sprite loads at the field extremes, first one under the reset mode
  task automatic test_extremes;
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    send_sprite(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    send_sprite(32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
  endtask

  // one small set under every mode: depth ties, texture ties, runs split by sorting
  task automatic test_sort_modes;
    logic [skb_pkg::TEX_W-1:0]   tex_set   [5] = '{32'd5, 32'hFFFF_FFFF, 32'd5, 32'd0,
                                                   32'd5};
    logic [skb_pkg::DEPTH_W-1:0] depth_set [5] = '{32'h0001_0000, 32'hFFFF_FFFF,
                                                   32'h8000_0000, 32'h0001_0000,
                                                   32'h7FFF_FFFF};
    int m;
    int k;
    for (m = 0; m < 4; m++) begin
      write_mode(skb_pkg::mode_t'(m));
      for (k = 0; k < 5; k++) send_sprite(tex_set[k], depth_set[k], k == 4);
    end
  endtask

  // over capacity with the dropped last mark, exactly full, then the flag clears
  task automatic test_overflow;
    int k;
    write_mode(skb_pkg::MODE_DEPTH_DESC);
    sender_steady = 1'b1;
    sink_steady   = 1'b1;
    for (k = 0; k < CAPACITY + 2; k++)
      send_sprite(skb_pkg::TEX_W'(k % 3), $urandom(), k == CAPACITY + 1);
    write_mode(skb_pkg::MODE_TEX_ASC);
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    for (k = 0; k < CAPACITY; k++)
      send_sprite(skb_pkg::TEX_W'($urandom_range(0, 5)), $urandom(), k == CAPACITY - 1);
    send_sprite(32'd7, 32'd0, 1'b0);
    send_sprite(32'd7, 32'd1, 1'b1);
  endtask

  // random loads: mostly short, textures and depths often from narrow pools so runs and ties form
  task automatic test_random_loads;
    int                          target;
    int                          n;
    int                          k;
    int                          tex_style;
    int                          depth_style;
    logic [skb_pkg::TEX_W-1:0]   tex;
    logic [skb_pkg::DEPTH_W-1:0] depth;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 2) == 0) write_mode(skb_pkg::mode_t'($urandom_range(0, 3)));
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 24))
        0:       n = $urandom_range(CAPACITY - 4, CAPACITY + 3);
        1, 2, 3: n = $urandom_range(9, 32);
        default: n = $urandom_range(1, 8);
      endcase
      tex_style   = $urandom_range(0, 2);
      depth_style = $urandom_range(0, 2);
      for (k = 0; k < n; k++) begin
        case (tex_style)
          0: begin
            case ($urandom_range(0, 2))
              0:       tex = 32'h0;
              1:       tex = 32'h1;
              default: tex = 32'hFFFF_FFFF;
            endcase
          end
          1:       tex = 32'h1000 + $urandom_range(0, 3);
          default: tex = $urandom();
        endcase
        case (depth_style)
          0: begin
            case ($urandom_range(0, 4))
              0:       depth = 32'hFFFF_FFFF;
              1:       depth = 32'h0;
              2:       depth = 32'h0001_0000;
              3:       depth = 32'h8000_0000;
              default: depth = 32'h7FFF_FFFF;
            endcase
          end
          // small signed values around zero in Q16.16
          1:       depth = skb_pkg::DEPTH_W'(($urandom_range(0, 6) - 3) <<< 16);
          default: depth = $urandom();
        endcase
        send_sprite(tex, depth, k == n - 1);
      end
    end
  endtask

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("** sprite_key_sort_and_batch: FAILED **");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    sprites.valid   = 1'b0;
    sprites.payload = '0;
    cfg.valid       = 1'b0;
    cfg.payload     = skb_pkg::MODE_NONE;
    shadow_count    = 0;
    shadow_overflow = 1'b0;
    shadow_mode     = skb_pkg::MODE_NONE;
    mismatches      = 0;
    unexpected      = 0;
    items_sent      = 0;
    sender_steady   = 1'b0;
    sink_steady     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_sort_modes();
    test_overflow();
    test_random_loads();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && unexpected == 0 && batch_queue.size() == 0) begin
      $display("** sprite_key_sort_and_batch: PASSED **");
    end else begin
      $display("** sprite_key_sort_and_batch: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sprite_key_sort_and_batch.f
design/skb_pkg.sv
design/skb_stream_if.sv
design/skb_cell.sv
design/skb_ctrl.sv
design/sprite_key_sort_and_batch.sv
tb/tb.sv
